// File: hdl/ibr_pkg.sv
package ibr_pkg;

  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int DimW       = ColW + 1;
  localparam int HdimW      = RowW + 1;
  localparam int AddrW      = ColW + RowW;
  localparam int CountW     = AddrW + 1;
  localparam int SumW       = 16 + AddrW;
  // channel sums over a full frame must fit the divider
  localparam int DivW       = SumW;
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_SRC_W  = 3'd1,
    REG_SRC_H  = 3'd2,
    REG_TGT_W  = 3'd3,
    REG_TGT_H  = 3'd4,
    REG_FACTOR = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_READ,
    ST_MEAN,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic        mode;
    logic [DimW-1:0]  sw;
    logic [HdimW-1:0] sh;
    logic [DimW-1:0]  ow;
    logic [HdimW-1:0] oh;
    logic [11:0] factor;
  } cfg_t;

  // emit job handed from front to back
  typedef struct packed {
    logic [ColW-1:0] x;
    logic [RowW-1:0] y;
    logic            last;
  } job_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] sat;
    logic [15:0] lum;
    logic [15:0] alpha;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic        last;
  } result_t;

endpackage

// File: hdl/ibr_front.sv
module ibr_front import ibr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind_i,
  input  logic        back_busy_i,
  output logic        wr_en_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);

  logic [CountW-1:0] load_q, load_d;
  logic [DimW-1:0]  col_q, col_d;
  logic [HdimW-1:0] row_q, row_d;
  logic [CountW-1:0] area;
  logic [CountW-1:0] idx;
  logic [DimW-1:0]  cx;
  logic [HdimW-1:0] ry, ry0;
  logic empty;
  logic fire;

  assign area  = CountW'(cfg_i.sw) * CountW'(cfg_i.sh);
  assign empty = (cfg_i.ow == '0) || (cfg_i.oh == '0);
  // loads must not overtake reads of an emit still in flight
  assign in_ready = kind_i ? job_ready_i : !back_busy_i;
  assign fire = in_valid && in_ready;

  assign idx       = (load_q >= area) ? '0 : load_q;
  assign wr_en_o   = fire && !kind_i;
  assign wr_addr_o = idx[AddrW-1:0];

  always_comb begin
    cx  = col_q;
    ry0 = row_q;
    if (col_q >= cfg_i.ow) begin
      cx  = '0;
      ry0 = row_q + 1'b1;
    end
    ry = (ry0 >= cfg_i.oh) ? '0 : ry0;
  end

  assign job_valid_o = fire && kind_i && !empty;
  assign job_o.x     = cx[ColW-1:0];
  assign job_o.y     = ry[RowW-1:0];
  assign job_o.last  = (cx == cfg_i.ow - 1'b1) && (HdimW'(ry) == cfg_i.oh - 1'b1);

  always_comb begin
    load_d = load_q;
    col_d  = col_q;
    row_d  = row_q;
    if (wr_en_o) load_d = idx + 1'b1;
    if (job_valid_o) begin
      if (cx + 1'b1 < cfg_i.ow) begin
        col_d = cx + 1'b1;
        row_d = ry;
      end else begin
        col_d = '0;
        row_d = (ry + 1'b1 < cfg_i.oh) ? ry + 1'b1 : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      load_q <= load_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

endmodule

// File: hdl/ibr_queue.sv
module ibr_queue import ibr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output job_t data_o
);

  localparam int PtrW = $clog2(QueueDepth);

  job_t mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

// File: hdl/ibr_divider.sv
module ibr_divider import ibr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [DivW-1:0] num_i,
  input  logic [DivW-1:0] den_i,
  output logic done_o,
  output logic [DivW-1:0] quo_o
);

  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0] q_q, q_d, den_q;
  logic [DivW:0]   r_q, r_d, trial;
  logic [CntW-1:0] cnt_q;
  logic busy_q;

  assign trial  = {r_q[DivW-1:0], q_q[DivW-1]} - {1'b0, den_q};
  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = q_q;

  always_comb begin
    if (!trial[DivW]) begin
      r_d = trial;
      q_d = {q_q[DivW-2:0], 1'b1};
    end else begin
      r_d = {r_q[DivW-1:0], q_q[DivW-1]};
      q_d = {q_q[DivW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DivW);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      r_q   <= '0;
      den_q <= den_i;
    end else if (busy_q && cnt_q != '0) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

endmodule

// File: hdl/ibr_back.sv
module ibr_back import ibr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [63:0] wr_data_i,
  input  logic job_valid_i,
  output logic job_pop_o,
  input  job_t job_i,
  output logic busy_o,
  output logic res_valid_o,
  input  logic res_ready_i,
  output result_t res_o
);

  back_state_e st_q, st_d;
  logic [63:0] store [MaxWidth*MaxHeight];
  logic [63:0] rd_q;
  logic [2:0] phase_q, phase_d;
  logic div_start, div_done;
  logic [DivW-1:0] div_num, div_den, div_quo;
  job_t job_q;
  logic [DimW-1:0]  x0_q, bw_q, i_q;
  logic [HdimW-1:0] y0_q, bh_q, j_q;
  logic [CountW-1:0] n_q;
  logic [SumW-1:0] hs_q, ss_q, ls_q, as_q;
  logic [14:0] avg_h_q;
  logic [15:0] avg_s_q, avg_l_q, avg_a_q;
  logic [DimW-1:0] cx;
  logic [HdimW-1:0] ry;
  logic [AddrW-1:0] rd_addr;
  logic rd_en, rd_v_q, acc_last_q;
  logic res_v_q;
  result_t res_q;
  logic [DivW-1:0] factor;

  assign factor = (cfg_i.factor == '0) ? DivW'(1) : DivW'(cfg_i.factor);

  ibr_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // phases: 0 x-start,1 y-start,2 bw,3 bh,4..7 mean of four channels
  always_comb begin
    div_num = '0;
    div_den = DivW'(1);
    case (phase_q)
      3'd0: begin
        div_num = cfg_i.mode ? DivW'({job_q.x, 8'd0}) : DivW'(job_q.x) * DivW'(cfg_i.sw);
        div_den = cfg_i.mode ? factor : DivW'(cfg_i.ow);
      end
      3'd1: begin
        div_num = cfg_i.mode ? DivW'({job_q.y, 8'd0}) : DivW'(job_q.y) * DivW'(cfg_i.sh);
        div_den = cfg_i.mode ? factor : DivW'(cfg_i.oh);
      end
      3'd2: begin div_num = DivW'(cfg_i.sw); div_den = DivW'(cfg_i.ow); end
      3'd3: begin div_num = DivW'(cfg_i.sh); div_den = DivW'(cfg_i.oh); end
      3'd4: begin div_num = DivW'(hs_q); div_den = DivW'(n_q); end
      3'd5: begin div_num = DivW'(ss_q); div_den = DivW'(n_q); end
      3'd6: begin div_num = DivW'(ls_q); div_den = DivW'(n_q); end
      default: begin div_num = DivW'(as_q); div_den = DivW'(n_q); end
    endcase
  end

  assign cx = (x0_q + i_q >= cfg_i.sw) ? cfg_i.sw - 1'b1 : x0_q + i_q;
  assign ry = (y0_q + j_q >= cfg_i.sh) ? cfg_i.sh - 1'b1 : y0_q + j_q;
  assign rd_addr = AddrW'(ry) * AddrW'(cfg_i.sw) + AddrW'(cx);

  always_comb begin
    st_d = st_q;
    phase_d = phase_q;
    case (st_q)
      ST_IDLE:  if (job_valid_i) st_d = ST_SETUP;
      ST_SETUP: st_d = ST_DIV;
      ST_DIV: if (div_done) begin
        if (phase_q == 3'd7 || (cfg_i.mode && phase_q == 3'd1)) begin
          st_d = ST_READ; phase_d = '0;
        end else if (phase_q == 3'd3) begin
          st_d = ST_READ;
        end else begin
          phase_d = phase_q + 1'b1; st_d = ST_SETUP;
        end
      end
      ST_READ:  if (acc_last_q) st_d = (cfg_i.mode) ? ST_OUT : ST_MEAN;
      ST_MEAN:  begin phase_d = 3'd4; st_d = ST_SETUP; end
      ST_OUT:   if (!res_v_q || res_ready_i) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
    if (st_q == ST_DIV && div_done && phase_q == 3'd7) st_d = ST_OUT;
  end

  always_comb begin
    div_start = (st_q == ST_SETUP);
    rd_en     = (st_q == ST_READ) && !acc_last_q;
    job_pop_o = (st_q == ST_IDLE) && job_valid_i;
    busy_o    = (st_q != ST_IDLE) || job_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) store[wr_addr_i] <= wr_data_i;
    if (rd_en) rd_q <= store[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      phase_q <= '0;
      rd_v_q <= 1'b0;
      acc_last_q <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      phase_q <= phase_d;
      rd_v_q <= rd_en;
      if (st_q != ST_READ) acc_last_q <= 1'b0;
      else if (rd_en && i_q + 1'b1 >= bw_q && j_q + 1'b1 >= bh_q) acc_last_q <= 1'b1;
      if (res_v_q && res_ready_i) res_v_q <= 1'b0;
      if (st_q == ST_OUT && (!res_v_q || res_ready_i)) res_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q <= job_i;
    if (st_q == ST_DIV && div_done) begin
      case (phase_q)
        // nearest-mode start can land past the frame edge: clamp to last column/row
        3'd0: begin
          x0_q <= (div_quo >= DivW'(cfg_i.sw)) ? cfg_i.sw - 1'b1 : DimW'(div_quo);
          bw_q <= DimW'(1);
        end
        3'd1: begin
          y0_q <= (div_quo >= DivW'(cfg_i.sh)) ? cfg_i.sh - 1'b1 : HdimW'(div_quo);
          bh_q <= HdimW'(1);
        end
        3'd2: bw_q <= (div_quo == '0) ? DimW'(1) : DimW'(div_quo);
        3'd3: bh_q <= (div_quo == '0) ? HdimW'(1) : HdimW'(div_quo);
        3'd4: avg_h_q <= div_quo[14:0];
        3'd5: avg_s_q <= div_quo[15:0];
        3'd6: avg_l_q <= div_quo[15:0];
        default: avg_a_q <= div_quo[15:0];
      endcase
    end
    if (st_q == ST_SETUP && phase_q == 3'd0) begin
      i_q <= '0; j_q <= '0;
      hs_q <= '0; ss_q <= '0; ls_q <= '0; as_q <= '0;
    end
    if (rd_en) begin
      if (i_q + 1'b1 >= bw_q) begin i_q <= '0; j_q <= j_q + 1'b1; end
      else i_q <= i_q + 1'b1;
    end
    if (rd_v_q) begin
      hs_q <= hs_q + SumW'(rd_q[14:0]);
      ss_q <= ss_q + SumW'(rd_q[31:16]);
      ls_q <= ls_q + SumW'(rd_q[47:32]);
      as_q <= as_q + SumW'(rd_q[63:48]);
    end
    if (st_q == ST_MEAN) n_q <= CountW'(bw_q) * CountW'(bh_q);
    // output register only changes once the previous beat has gone
    if (st_q == ST_OUT && (!res_v_q || res_ready_i)) begin
      if (cfg_i.mode) begin
        res_q.hue <= rd_q[14:0];
        res_q.sat <= rd_q[31:16];
        res_q.lum <= rd_q[47:32];
        res_q.alpha <= rd_q[63:48];
      end else begin
        res_q.hue <= avg_h_q;
        res_q.sat <= avg_s_q;
        res_q.lum <= avg_l_q;
        res_q.alpha <= avg_a_q;
      end
      res_q.col <= job_q.x;
      res_q.row <= job_q.y;
      res_q.last <= job_q.last;
    end
  end

  assign res_valid_o = res_v_q;
  always_comb begin
    res_o = res_q;
  end

endmodule

// File: hdl/image_box_resize.sv
// HSLA frame resizer.
// Input channel (in_valid/in_ready): kind_i=0 beats write source pixels into
// the frame store in raster order; kind_i=1 beats request the next output
// pixel. Output channel (out_valid/out_ready) returns one pixel per request,
// with its column, row and an end-of-frame flag. Nearest mode with an empty
// output size returns nothing.
// Configuration: cfg_we/cfg_idx/cfg_data, to be written only while idle (not enforced).
// A load is written on its accepting edge, but is held off while any request
// is queued or in the back end. A request goes through a two-entry job queue
// into a back end with a radix-2 divider that reads the store once per cycle.
// Per request: nearest mode two coordinate divisions and one store read;
// box mode four coordinate divisions, bw*bh store reads and four mean
// divisions. The shared divider sets the rate.
// A result waits in an output register; a stalled receiver holds it while
// the next job proceeds up to the output stage.
// Reset clears the load count and emit position and restores default
// registers; the frame store contents are undefined until loaded.
module image_box_resize import ibr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind_i,
  input  logic [14:0] hue_in_i,
  input  logic [15:0] sat_in_i,
  input  logic [15:0] lum_in_i,
  input  logic [15:0] alpha_in_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] hue_out_o,
  output logic [15:0] sat_out_o,
  output logic [15:0] lum_out_o,
  output logic [15:0] alpha_out_o,
  output logic [7:0]  out_column_o,
  output logic [7:0]  out_row_o,
  output logic        last_pixel_o,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [11:0] cfg_data
);

  logic        mode_q;
  logic [8:0]  sw_q, sh_q, tw_q, th_q;
  logic [11:0] factor_q;
  cfg_t cfg;
  logic [DimW-1:0]  sw_c, tw_c;
  logic [HdimW-1:0] sh_c, th_c;
  logic [20:0] nw, nh;
  logic [DivW-1:0] fac;
  logic wr_en, q_push, q_full, q_valid, q_pop, back_busy;
  logic [AddrW-1:0] wr_addr;
  job_t job_in, job_out;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      sw_q <= 9'd256; sh_q <= 9'd256; tw_q <= 9'd256; th_q <= 9'd256;
      factor_q <= 12'd256;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MODE:   mode_q <= cfg_data[0];
        REG_SRC_W:  sw_q <= cfg_data[8:0];
        REG_SRC_H:  sh_q <= cfg_data[8:0];
        REG_TGT_W:  tw_q <= cfg_data[8:0];
        REG_TGT_H:  th_q <= cfg_data[8:0];
        REG_FACTOR: factor_q <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sw_c = (sw_q == '0) ? DimW'(1) : (sw_q > 9'(MaxWidth)) ? DimW'(MaxWidth) : DimW'(sw_q);
    sh_c = (sh_q == '0) ? HdimW'(1) : (sh_q > 9'(MaxHeight)) ? HdimW'(MaxHeight) : HdimW'(sh_q);
    tw_c = (tw_q == '0) ? DimW'(1) : (tw_q > 9'(MaxWidth)) ? DimW'(MaxWidth) : DimW'(tw_q);
    th_c = (th_q == '0) ? HdimW'(1) : (th_q > 9'(MaxHeight)) ? HdimW'(MaxHeight) : HdimW'(th_q);
    fac  = (factor_q == '0) ? DivW'(1) : DivW'(factor_q);
    nw = 21'((fac * DivW'(sw_c)) >> 8);
    nh = 21'((fac * DivW'(sh_c)) >> 8);
    cfg.mode = mode_q;
    cfg.sw = sw_c;
    cfg.sh = sh_c;
    cfg.factor = factor_q;
    if (mode_q) begin
      cfg.ow = (nw > 21'(MaxWidth)) ? DimW'(MaxWidth) : DimW'(nw);
      cfg.oh = (nh > 21'(MaxHeight)) ? HdimW'(MaxHeight) : HdimW'(nh);
    end else begin
      cfg.ow = tw_c;
      cfg.oh = th_c;
    end
  end

  ibr_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_valid, .in_ready, .kind_i,
    .back_busy_i(back_busy || q_valid), .wr_en_o(wr_en), .wr_addr_o(wr_addr),
    .job_valid_o(q_push), .job_ready_i(!q_full), .job_o(job_in)
  );

  ibr_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(job_in), .full_o(q_full),
    .valid_o(q_valid), .pop_i(q_pop), .data_o(job_out)
  );

  ibr_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .wr_en_i(wr_en), .wr_addr_i(wr_addr),
    .wr_data_i({alpha_in_i, lum_in_i, sat_in_i, 1'b0, hue_in_i}),
    .job_valid_i(q_valid), .job_pop_o(q_pop), .job_i(job_out),
    .busy_o(back_busy), .res_valid_o(out_valid), .res_ready_i(out_ready),
    .res_o(res)
  );

  assign hue_out_o    = res.hue;
  assign sat_out_o    = res.sat;
  assign lum_out_o    = res.lum;
  assign alpha_out_o  = res.alpha;
  assign out_column_o = 8'(res.col);
  assign out_row_o    = 8'(res.row);
  assign last_pixel_o = res.last;

`ifndef NO_ASSERTIONS
  a_no_load_during_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !back_busy) else $error("load while emit in flight");
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("job queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("job queue underflow");
`endif

endmodule

// File: tb/image_box_resize_tb.sv
`timescale 1ns / 100ps

module image_box_resize_tb;
  import ibr_pkg::*;

  localparam int DrainCycles = 700;
  localparam longint CycleLimit = 4_000_000;
  localparam int ItemTarget = 1650;

  typedef enum logic [1:0] {OP_CFG, OP_LOAD, OP_EMIT} row_op_e;

  typedef struct packed {
    logic [14:0] h;
    logic [15:0] s;
    logic [15:0] l;
    logic [15:0] a;
  } hsla_t;

  typedef struct packed {
    row_op_e     op;
    reg_idx_e    idx;
    logic [11:0] data;
    hsla_t       pix;
    logic        typed;
    result_t     want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind_i = 1'b0;
  logic [14:0] hue_in_i = '0;
  logic [15:0] sat_in_i = '0;
  logic [15:0] lum_in_i = '0;
  logic [15:0] alpha_in_i = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [14:0] hue_out_o;
  logic [15:0] sat_out_o;
  logic [15:0] lum_out_o;
  logic [15:0] alpha_out_o;
  logic [7:0]  out_column_o;
  logic [7:0]  out_row_o;
  logic        last_pixel_o;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [11:0] cfg_data = '0;

  image_box_resize DUT (.*);

  always #1 clk_i = ~clk_i;

  // shadow of the block: registers, store, positions
  logic        sh_mode;
  logic [8:0]  sh_srcw, sh_srch, sh_tgtw, sh_tgth;
  logic [11:0] sh_fac;
  hsla_t       pix_store [0:65535];
  int unsigned load_pos, loaded_top, emit_x, emit_y;

  result_t     pending_px[$];
  int          fails = 0;
  int          items_done = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  longint      cycles = 0;

  function automatic int unsigned clamp_dim(logic [8:0] v);
    if (v == 0) return 1;
    if (v > MaxWidth) return MaxWidth;
    return v;
  endfunction

  function automatic hsla_t fetch(int unsigned c, int unsigned r,
                                  int unsigned sw, int unsigned sh);
    if (c >= sw) c = sw - 1;
    if (r >= sh) r = sh - 1;
    return pix_store[r * sw + c];
  endfunction

  function automatic void store_pixel(hsla_t p);
    int unsigned sw, sh, idx;
    sw = clamp_dim(sh_srcw);
    sh = clamp_dim(sh_srch);
    idx = load_pos;
    if (idx >= sw * sh) idx = 0;
    pix_store[idx] = p;
    load_pos = idx + 1;
    if (load_pos > loaded_top) loaded_top = load_pos;
  endfunction

  // next output pixel; returns 0 when the nearest-mode frame is empty
  function automatic bit next_output(output result_t r);
    int unsigned sw, sh, ow, oh, f, bw, bh, x0, y0, x, y;
    longint unsigned hs, ss, ls, as_;
    hsla_t p;
    sw = clamp_dim(sh_srcw);
    sh = clamp_dim(sh_srch);
    f = (sh_fac == 0) ? 1 : sh_fac;
    hs = 0; ss = 0; ls = 0; as_ = 0;
    r = '0;
    if (!sh_mode) begin
      ow = clamp_dim(sh_tgtw);
      oh = clamp_dim(sh_tgth);
    end else begin
      ow = (f * sw) >> 8;
      oh = (f * sh) >> 8;
      if (ow > MaxWidth) ow = MaxWidth;
      if (oh > MaxHeight) oh = MaxHeight;
      if (ow == 0 || oh == 0) return 0;
    end
    if (emit_x >= ow) begin
      emit_x = 0;
      emit_y++;
    end
    if (emit_y >= oh) emit_y = 0;
    x = emit_x;
    y = emit_y;
    if (!sh_mode) begin
      bw = sw / ow;
      bh = sh / oh;
      if (bw < 1) bw = 1;
      if (bh < 1) bh = 1;
      x0 = (x * sw) / ow;
      y0 = (y * sh) / oh;
      for (int j = 0; j < bh; j++)
        for (int i = 0; i < bw; i++) begin
          p = fetch(x0 + i, y0 + j, sw, sh);
          hs += p.h; ss += p.s; ls += p.l; as_ += p.a;
        end
      hs /= bw * bh; ss /= bw * bh; ls /= bw * bh; as_ /= bw * bh;
    end else begin
      p = fetch((x << 8) / f, (y << 8) / f, sw, sh);
      hs = p.h; ss = p.s; ls = p.l; as_ = p.a;
    end
    r.hue = hs[14:0];
    r.sat = ss[15:0];
    r.lum = ls[15:0];
    r.alpha = as_[15:0];
    r.col = x[7:0];
    r.row = y[7:0];
    r.last = (x == ow - 1 && y == oh - 1);
    if (x + 1 < ow) emit_x = x + 1;
    else begin
      emit_x = 0;
      emit_y = (y + 1 < oh) ? y + 1 : 0;
    end
    return 1;
  endfunction

  task automatic wait_drained();
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // caller lowers cfg_we after the last write of a batch
  task automatic write_reg(reg_idx_e i, logic [11:0] d);
    cfg_we <= 1'b1;
    cfg_idx <= i;
    cfg_data <= d;
    @(posedge clk_i);
    case (i)
      REG_MODE:   sh_mode = d[0];
      REG_SRC_W:  sh_srcw = d[8:0];
      REG_SRC_H:  sh_srch = d[8:0];
      REG_TGT_W:  sh_tgtw = d[8:0];
      REG_TGT_H:  sh_tgth = d[8:0];
      REG_FACTOR: sh_fac = d;
      default: ;
    endcase
  endtask

  task automatic send_beat(logic k, hsla_t p, logic typed, result_t want);
    result_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind_i <= k;
    hue_in_i <= p.h;
    sat_in_i <= p.s;
    lum_in_i <= p.l;
    alpha_in_i <= p.a;
    do @(posedge clk_i); while (!in_ready);
    if (!k) begin
      store_pixel(p);
      items_done++;
    end else if (next_output(r)) begin
      pending_px.push_back(typed ? want : r);
      items_done++;
    end
  endtask

  function automatic hsla_t rand_pixel();
    hsla_t p;
    if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 1) ? '1 : '0;
    else begin
      p.h = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                         : 15'($urandom_range(0, 23040));
      p.s = $urandom_range(0, 65535);
      p.l = $urandom_range(0, 65535);
      p.a = $urandom_range(0, 65535);
    end
    return p;
  endfunction

  function automatic logic [8:0] rand_dim(int unsigned hi);
    case ($urandom_range(0, 15))
      0: return 9'd0;
      1: return 9'd511;
      default: return 9'($urandom_range(1, hi));
    endcase
  endfunction

  // receiver: random stalls plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 12) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_px.size() == 0) begin
        $error("output beat with nothing expected");
        fails++;
      end else begin
        e = pending_px.pop_front();
        if (hue_out_o !== e.hue) begin
          $error("hue_out exp %0d got %0d", e.hue, hue_out_o); fails++;
        end
        if (sat_out_o !== e.sat) begin
          $error("sat_out exp %0d got %0d", e.sat, sat_out_o); fails++;
        end
        if (lum_out_o !== e.lum) begin
          $error("lum_out exp %0d got %0d", e.lum, lum_out_o); fails++;
        end
        if (alpha_out_o !== e.alpha) begin
          $error("alpha_out exp %0d got %0d", e.alpha, alpha_out_o); fails++;
        end
        if (out_column_o !== e.col) begin
          $error("out_column exp %0d got %0d", e.col, out_column_o); fails++;
        end
        if (out_row_o !== e.row) begin
          $error("out_row exp %0d got %0d", e.row, out_row_o); fails++;
        end
        if (last_pixel_o !== e.last) begin
          $error("last_pixel exp %0d got %0d", e.last, last_pixel_o); fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic dir_row_t cfg_row(reg_idx_e i, logic [11:0] d);
    dir_row_t t = '0;
    t.op = OP_CFG; t.idx = i; t.data = d;
    return t;
  endfunction

  function automatic dir_row_t px_row(row_op_e op, hsla_t p, logic typed, result_t w);
    dir_row_t t = '0;
    t.op = op; t.pix = p; t.typed = typed; t.want = w;
    return t;
  endfunction

  initial begin
    dir_row_t steps[$];
    result_t none, avg_first, avg_wrap, zero_px;
    int unsigned sw, sh, n_body, phase;
    hsla_t p;

    sh_mode = 1'b0; sh_srcw = 9'd256; sh_srch = 9'd256;
    sh_tgtw = 9'd256; sh_tgth = 9'd256; sh_fac = 12'd256;
    load_pos = 0; loaded_top = 0; emit_x = 0; emit_y = 0;

    none = '0;
    avg_first = '{hue: 15'd16383, sat: 16'd32767, lum: 16'd32767, alpha: 16'd32767,
                  col: 8'd0, row: 8'd0, last: 1'b1};
    avg_wrap = avg_first;
    zero_px = '0;

    // two extreme pixels averaged to one, then nearest with a zero factor
    // (empty frame), maximum factor, and a target shrink that wraps the position
    steps.push_back(cfg_row(REG_SRC_W, 12'd2));
    steps.push_back(cfg_row(REG_SRC_H, 12'd1));
    steps.push_back(cfg_row(REG_TGT_W, 12'd1));
    steps.push_back(cfg_row(REG_TGT_H, 12'd1));
    steps.push_back(px_row(OP_LOAD, '0, 1'b0, none));
    steps.push_back(px_row(OP_LOAD, '1, 1'b0, none));
    steps.push_back(px_row(OP_EMIT, '0, 1'b1, avg_first));
    steps.push_back(cfg_row(REG_MODE, 12'd1));
    steps.push_back(cfg_row(REG_FACTOR, 12'd0));
    steps.push_back(px_row(OP_EMIT, '0, 1'b0, none));
    steps.push_back(cfg_row(REG_FACTOR, 12'd4095));
    steps.push_back(px_row(OP_EMIT, '0, 1'b1, zero_px));
    steps.push_back(px_row(OP_EMIT, '0, 1'b0, none));
    steps.push_back(px_row(OP_EMIT, '0, 1'b0, none));
    steps.push_back(cfg_row(REG_MODE, 12'hffe));
    steps.push_back(cfg_row(REG_TGT_W, 12'd0));
    steps.push_back(px_row(OP_EMIT, '0, 1'b1, avg_wrap));
    steps.push_back(px_row(OP_LOAD, '1, 1'b0, none));
    steps.push_back(px_row(OP_EMIT, '0, 1'b0, none));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[i]) begin
      if (steps[i].op == OP_CFG) begin
        in_valid <= 1'b0;
        wait_drained();
        write_reg(steps[i].idx, steps[i].data);
        cfg_we <= 1'b0;
      end else begin
        send_beat(steps[i].op == OP_EMIT, steps[i].pix, steps[i].typed, steps[i].want);
      end
    end

    phase = 0;
    while (items_done < ItemTarget) begin
      if (items_done > ItemTarget - 250) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      in_valid <= 1'b0;
      wait_drained();
      write_reg(REG_MODE, 12'($urandom_range(0, 4095)));
      case ($urandom_range(0, 9))
        0: begin
          write_reg(REG_SRC_W, ($urandom_range(0, 1)) ? 12'd511 : 12'd256);
          write_reg(REG_SRC_H, 12'($urandom_range(0, 1)));
        end
        1: begin
          write_reg(REG_SRC_W, 12'($urandom_range(0, 2)));
          write_reg(REG_SRC_H, ($urandom_range(0, 1)) ? 12'd300 : 12'd256);
        end
        default: begin
          write_reg(REG_SRC_W, 12'(rand_dim(12)) & 12'h1ff & (12'($urandom_range(0, 3)) == 0 ?
                    12'h1ff : 12'h00f));
          write_reg(REG_SRC_H, 12'($urandom_range(1, 10)));
        end
      endcase
      write_reg(REG_TGT_W, {3'($urandom_range(0, 7)), rand_dim(14)});
      write_reg(REG_TGT_H, 12'(rand_dim(14)));
      case ($urandom_range(0, 7))
        0: write_reg(REG_FACTOR, 12'd0);
        1: write_reg(REG_FACTOR, 12'd4095);
        2: write_reg(REG_FACTOR, 12'($urandom_range(1, 60)));
        default: write_reg(REG_FACTOR, 12'($urandom_range(1, 1024)));
      endcase
      cfg_we <= 1'b0;

      sw = clamp_dim(sh_srcw);
      sh = clamp_dim(sh_srch);
      // reload the frame when the old one does not cover it, and at random otherwise
      if (loaded_top < sw * sh || $urandom_range(0, 1) == 0)
        for (int i = 0; i < sw * sh; i++) send_beat(1'b0, rand_pixel(), 1'b0, none);
      if (phase == 4) hold_req = 1'b1;
      n_body = $urandom_range(5, 40);
      for (int i = 0; i < n_body; i++) begin
        p = rand_pixel();
        send_beat(($urandom_range(0, 6) != 0), p, 1'b0, none);
      end
      phase++;
    end

    in_valid <= 1'b0;
    wait_drained();
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
